[rtl/core/brle_pkg.sv]
package brle_pkg;

  localparam int RUN_COUNT_BITS_DEF = 24;
  localparam int TOTAL_W = 28;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [7:0] RUN_CAP = 8'd255;
  localparam logic [3:0] CODE_W_MAX = 4'd8;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END = 1'b1;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_CODE = 1'b1;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_BASE_VALUE   = 3'd1,
    REG_BASE_REPEATS = 3'd2,
    REG_VALUE_BITS   = 3'd3,
    REG_REPEATS_BITS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] base_value;
    logic [7:0] base_repeats;
    logic [3:0] value_bits;
    logic [3:0] repeats_bits;
  } cfg_t;

  // pending result between the run tracker and the output formatter
  typedef struct packed {
    logic       kind;
    logic       last;
    logic [7:0] value_code;
    logic [3:0] value_len;
    logic [7:0] repeats_code;
    logic [3:0] repeats_len;
    logic [7:0] low_value;
    logic [7:0] high_value;
    logic [7:0] low_repeats;
    logic [7:0] high_repeats;
  } pend_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         value_code;
    logic [3:0]         value_len;
    logic [7:0]         repeats_code;
    logic [3:0]         repeats_len;
    logic [7:0]         low_value;
    logic [7:0]         high_value;
    logic [7:0]         low_repeats;
    logic [7:0]         high_repeats;
    logic [TOTAL_W-1:0] total_bits;
    logic               last;
  } out_word_t;

  function automatic logic [3:0] clamp_width(input logic [3:0] w);
    return (w > CODE_W_MAX) ? CODE_W_MAX : w;
  endfunction

  // keep the low w bits, w already clamped to 8
  function automatic logic [7:0] code_cut(input logic [7:0] v, input logic [3:0] w);
    logic [8:0] mask;
    mask = (9'd1 << w) - 9'd1;
    return v & mask[7:0];
  endfunction

  // position of the highest set bit plus one, zero for zero
  function automatic logic [3:0] bits_needed(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[rtl/core/brle_in_if.sv]
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data;

  modport source (output valid, output action, output data, input ready);
  modport sink (input valid, input action, input data, output ready);
endinterface

[rtl/core/brle_out_if.sv]
interface brle_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  value_code;
  logic [3:0]  value_len;
  logic [7:0]  repeats_code;
  logic [3:0]  repeats_len;
  logic [7:0]  low_value;
  logic [7:0]  high_value;
  logic [7:0]  low_repeats;
  logic [7:0]  high_repeats;
  logic [27:0] total_bits;
  logic        last;

  modport source (
    output valid, output kind, output value_code, output value_len,
    output repeats_code, output repeats_len, output low_value, output high_value,
    output low_repeats, output high_repeats, output total_bits, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input value_code, input value_len,
    input repeats_code, input repeats_len, input low_value, input high_value,
    input low_repeats, input high_repeats, input total_bits, input last,
    output ready
  );
endinterface

[rtl/core/brle_cfg_if.sv]
interface brle_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] idx;
  logic [7:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

[rtl/core/brle_tracker.sv]
module brle_tracker
  import brle_pkg::*;
#(
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic                      action,
  input  logic [7:0]                data,
  input  cfg_t                      cfg,
  output logic                      res_valid,
  output pend_t                     res,
  output logic [RUN_COUNT_BITS-1:0] res_count
);

  logic [7:0]                run_byte_r, run_byte_nxt;
  logic [7:0]                run_len_r, run_len_nxt;
  logic [RUN_COUNT_BITS-1:0] run_total_r, run_total_nxt;
  logic [7:0]                seen_lv_r, seen_lv_nxt;
  logic [7:0]                seen_hv_r, seen_hv_nxt;
  logic [7:0]                seen_lr_r, seen_lr_nxt;
  logic [7:0]                seen_hr_r, seen_hr_nxt;

  logic [7:0]                cl_lv, cl_hv, cl_lr, cl_hr;
  logic [RUN_COUNT_BITS-1:0] cl_total;
  pend_t                     coded;
  pend_t                     summary;
  logic [3:0]                vb, rb;

  // statistics with the open run folded in
  assign cl_lv = (run_byte_r < seen_lv_r) ? run_byte_r : seen_lv_r;
  assign cl_hv = (run_byte_r > seen_hv_r) ? run_byte_r : seen_hv_r;
  assign cl_lr = (run_len_r < seen_lr_r) ? run_len_r : seen_lr_r;
  assign cl_hr = (run_len_r > seen_hr_r) ? run_len_r : seen_hr_r;
  assign cl_total = (&run_total_r) ? run_total_r
                                   : RUN_COUNT_BITS'(run_total_r + 1'b1);

  assign vb = clamp_width(cfg.value_bits);
  assign rb = clamp_width(cfg.repeats_bits);

  always_comb begin
    coded = '0;
    coded.kind = KIND_RUN;
    coded.value_code = code_cut(8'(run_byte_r - cfg.base_value), vb);
    coded.value_len = vb;
    coded.repeats_code = code_cut(8'(run_len_r - cfg.base_repeats), rb);
    coded.repeats_len = rb;

    summary = '0;
    summary.kind = KIND_SUMMARY;
    summary.last = 1'b1;
    if (run_len_r != 8'd0) begin
      summary.low_value = cl_lv;
      summary.high_value = cl_hv;
      summary.low_repeats = cl_lr;
      summary.high_repeats = cl_hr;
    end
  end

  always_comb begin
    run_byte_nxt = run_byte_r;
    run_len_nxt = run_len_r;
    run_total_nxt = run_total_r;
    seen_lv_nxt = seen_lv_r;
    seen_hv_nxt = seen_hv_r;
    seen_lr_nxt = seen_lr_r;
    seen_hr_nxt = seen_hr_r;
    res_valid = 1'b0;
    res = coded;
    res_count = '0;

    if (fire) begin
      if (action == ACT_DATA) begin
        priority if (run_len_r == 8'd0) begin
          run_byte_nxt = data;
          run_len_nxt = 8'd1;
          seen_lv_nxt = data;
          seen_hv_nxt = data;
        end else if (run_byte_r == data && run_len_r != RUN_CAP) begin
          run_len_nxt = 8'(run_len_r + 1'b1);
        end else begin
          seen_lv_nxt = cl_lv;
          seen_hv_nxt = cl_hv;
          seen_lr_nxt = cl_lr;
          seen_hr_nxt = cl_hr;
          run_total_nxt = cl_total;
          run_byte_nxt = data;
          run_len_nxt = 8'd1;
          res_valid = (cfg.mode == MODE_CODE);
        end
      end else begin
        if (cfg.mode == MODE_CODE) begin
          res_valid = (run_len_r != 8'd0);
          res = coded;
          res.last = 1'b1;
        end else begin
          res_valid = 1'b1;
          res = summary;
          res_count = (run_len_r != 8'd0) ? cl_total : '0;
        end
        // block ends, statistics start over
        run_byte_nxt = 8'd0;
        run_len_nxt = 8'd0;
        run_total_nxt = '0;
        seen_lv_nxt = 8'd0;
        seen_hv_nxt = 8'd0;
        seen_lr_nxt = 8'd255;
        seen_hr_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r <= 8'd0;
      run_len_r <= 8'd0;
      run_total_r <= '0;
      seen_lv_r <= 8'd0;
      seen_hv_r <= 8'd0;
      seen_lr_r <= 8'd255;
      seen_hr_r <= 8'd0;
    end else begin
      run_byte_r <= run_byte_nxt;
      run_len_r <= run_len_nxt;
      run_total_r <= run_total_nxt;
      seen_lv_r <= seen_lv_nxt;
      seen_hv_r <= seen_hv_nxt;
      seen_lr_r <= seen_lr_nxt;
      seen_hr_r <= seen_hr_nxt;
    end
  end

endmodule

[rtl/core/brle_format.sv]
module brle_format
  import brle_pkg::*;
#(
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  pend_t                     pend,
  input  logic [RUN_COUNT_BITS-1:0] count,
  output out_word_t                 word
);

  localparam int PROD_W = RUN_COUNT_BITS + 5;
  localparam int CMP_W = (PROD_W > TOTAL_W) ? PROD_W : TOTAL_W;

  logic [3:0]        vl, rl;
  logic [4:0]        width_sum;
  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  prod_ext;

  assign vl = bits_needed(8'(pend.high_value - pend.low_value));
  assign rl = bits_needed(8'(pend.high_repeats - pend.low_repeats));
  assign width_sum = 5'(vl) + 5'(rl);
  assign prod = PROD_W'(count) * PROD_W'(width_sum);
  assign prod_ext = CMP_W'(prod);

  always_comb begin
    word = '0;
    word.kind = pend.kind;
    word.last = pend.last;
    if (pend.kind == KIND_SUMMARY) begin
      word.value_len = vl;
      word.repeats_len = rl;
      word.low_value = pend.low_value;
      word.high_value = pend.high_value;
      word.low_repeats = pend.low_repeats;
      word.high_repeats = pend.high_repeats;
      word.total_bits = (prod_ext > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                        : TOTAL_W'(prod_ext);
    end else begin
      word.value_code = pend.value_code;
      word.value_len = pend.value_len;
      word.repeats_code = pend.repeats_code;
      word.repeats_len = pend.repeats_len;
    end
  end

endmodule

[rtl/core/byte_run_length_scan_and_encode.sv]
// Byte run-length scanner and encoder. Takes one word per cycle and sustains one
// per cycle with no bubbles while the output side is ready; a result passes from
// the word that causes it through the input register, the run tracker into a
// pending register, then the summary math into the output register. Runs of equal bytes are capped at
// 255. In scan mode (mode 0) only the end-of-block word gives a result, a
// summary of the block; in code mode (mode 1) each closed run gives a coded
// word and the end-of-block word flushes the open run with last set. Ready
// follows the output handshake through the three registers combinationally.
// Write the configuration registers only while no word is in flight.
module byte_run_length_scan_and_encode
  import brle_pkg::*;
#(
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  brle_in_if.sink    in_bus,
  brle_out_if.source out_bus,
  brle_cfg_if.sink   cfg_bus
);

  cfg_t cfg_r;

  logic       s1_valid_r;
  logic       s1_action_r;
  logic [7:0] s1_data_r;

  logic                      s2_valid_r;
  pend_t                     s2_pend_r;
  logic [RUN_COUNT_BITS-1:0] s2_count_r;

  logic      out_valid_r;
  out_word_t out_word_r;

  logic                      out_free, s2_go, s2_free, s1_go, in_fire;
  logic                      trk_valid;
  pend_t                     trk_pend;
  logic [RUN_COUNT_BITS-1:0] trk_count;
  out_word_t                 fmt_word;

  assign out_free = !out_valid_r || out_bus.ready;
  assign s2_go = s2_valid_r && out_free;
  assign s2_free = !s2_valid_r || s2_go;
  assign s1_go = s1_valid_r && s2_free;
  assign in_bus.ready = !s1_valid_r || s1_go;
  assign in_fire = in_bus.valid && in_bus.ready;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_reg_t'(cfg_bus.idx))
        REG_MODE:         cfg_r.mode <= cfg_bus.wdata[0];
        REG_BASE_VALUE:   cfg_r.base_value <= cfg_bus.wdata;
        REG_BASE_REPEATS: cfg_r.base_repeats <= cfg_bus.wdata;
        REG_VALUE_BITS:   cfg_r.value_bits <= cfg_bus.wdata[3:0];
        REG_REPEATS_BITS: cfg_r.repeats_bits <= cfg_bus.wdata[3:0];
        default: ;
      endcase
    end
  end

  brle_tracker #(
    .RUN_COUNT_BITS(RUN_COUNT_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_go),
    .action    (s1_action_r),
    .data      (s1_data_r),
    .cfg       (cfg_r),
    .res_valid (trk_valid),
    .res       (trk_pend),
    .res_count (trk_count)
  );

  brle_format #(
    .RUN_COUNT_BITS(RUN_COUNT_BITS)
  ) u_format (
    .pend  (s2_pend_r),
    .count (s2_count_r),
    .word  (fmt_word)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_r <= trk_valid;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_bus.action;
      s1_data_r <= in_bus.data;
    end
    if (s1_go) begin
      s2_pend_r <= trk_pend;
      s2_count_r <= trk_count;
    end
    if (s2_go) begin
      out_word_r <= fmt_word;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.kind = out_word_r.kind;
  assign out_bus.value_code = out_word_r.value_code;
  assign out_bus.value_len = out_word_r.value_len;
  assign out_bus.repeats_code = out_word_r.repeats_code;
  assign out_bus.repeats_len = out_word_r.repeats_len;
  assign out_bus.low_value = out_word_r.low_value;
  assign out_bus.high_value = out_word_r.high_value;
  assign out_bus.low_repeats = out_word_r.low_repeats;
  assign out_bus.high_repeats = out_word_r.high_repeats;
  assign out_bus.total_bits = out_word_r.total_bits;
  assign out_bus.last = out_word_r.last;

endmodule

[tb/sv/brle_run_checker.sv]
`timescale 1ns / 1ps

module brle_run_checker
  import brle_pkg::*;
#(
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  brle_in_if          in_bus,
  brle_out_if         out_bus,
  brle_cfg_if         cfg_bus,
  output int unsigned fail_count,
  output int unsigned due_count
);

  cfg_t cur_cfg;

  logic [7:0]                run_val;
  logic [7:0]                run_len;
  logic [RUN_COUNT_BITS-1:0] runs_seen;
  logic [7:0]                val_lo;
  logic [7:0]                val_hi;
  logic [7:0]                len_lo;
  logic [7:0]                len_hi;

  out_word_t   due_words[$];
  int unsigned n_bad;

  function automatic logic [3:0] cap_width(input logic [3:0] w);
    return w[3] ? 4'd8 : w;
  endfunction

  function automatic logic [7:0] keep_low(input logic [7:0] v, input logic [3:0] n);
    for (int i = 0; i < 8; i++) begin
      if (i >= n) begin
        v[i] = 1'b0;
      end
    end
    return v;
  endfunction

  function automatic logic [3:0] span_width(input logic [7:0] span);
    logic [3:0] n;
    n = 4'd0;
    while (span != 8'd0) begin
      n++;
      span = span >> 1;
    end
    return n;
  endfunction

  task automatic clear_block();
    run_val = 8'd0;
    run_len = 8'd0;
    runs_seen = '0;
    val_lo = 8'd0;
    val_hi = 8'd0;
    len_lo = 8'd255;
    len_hi = 8'd0;
  endtask

  task automatic close_run();
    if (run_val < val_lo) val_lo = run_val;
    if (run_val > val_hi) val_hi = run_val;
    if (run_len < len_lo) len_lo = run_len;
    if (run_len > len_hi) len_hi = run_len;
    if (runs_seen != '1) runs_seen++;
  endtask

  function automatic out_word_t coded_run(input logic is_last);
    out_word_t w;
    logic [3:0] vw;
    logic [3:0] rw;
    vw = cap_width(cur_cfg.value_bits);
    rw = cap_width(cur_cfg.repeats_bits);
    w = '0;
    w.kind = KIND_RUN;
    w.value_code = keep_low(run_val - cur_cfg.base_value, vw);
    w.value_len = vw;
    w.repeats_code = keep_low(run_len - cur_cfg.base_repeats, rw);
    w.repeats_len = rw;
    w.last = is_last;
    return w;
  endfunction

  task automatic track_word(input logic act, input logic [7:0] b);
    out_word_t w;
    logic [3:0] vl;
    logic [3:0] rl;
    logic [63:0] bits;
    if (act == ACT_DATA) begin
      if (run_len == 8'd0) begin
        run_val = b;
        run_len = 8'd1;
        val_lo = b;
        val_hi = b;
      end else if (run_val == b && run_len < RUN_CAP) begin
        run_len++;
      end else begin
        close_run();
        if (cur_cfg.mode == MODE_CODE) due_words.push_back(coded_run(1'b0));
        run_val = b;
        run_len = 8'd1;
      end
    end else begin
      if (cur_cfg.mode == MODE_CODE) begin
        if (run_len != 8'd0) due_words.push_back(coded_run(1'b1));
      end else begin
        w = '0;
        w.kind = KIND_SUMMARY;
        w.last = 1'b1;
        // an empty block leaves every summary field but kind and last zero
        if (run_len != 8'd0) begin
          close_run();
          vl = span_width(val_hi - val_lo);
          rl = span_width(len_hi - len_lo);
          bits = 64'(runs_seen) * (64'(vl) + 64'(rl));
          if (bits > 64'(TOTAL_MAX)) bits = 64'(TOTAL_MAX);
          w.value_len = vl;
          w.repeats_len = rl;
          w.low_value = val_lo;
          w.high_value = val_hi;
          w.low_repeats = len_lo;
          w.high_repeats = len_hi;
          w.total_bits = bits[TOTAL_W-1:0];
        end
        due_words.push_back(w);
      end
      clear_block();
    end
  endtask

  task automatic check_field(input string name, input logic [27:0] want_v,
                             input logic [27:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      cur_cfg = '0;
      clear_block();
      due_words.delete();
      n_bad = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.idx)
          REG_MODE:         cur_cfg.mode = cfg_bus.wdata[0];
          REG_BASE_VALUE:   cur_cfg.base_value = cfg_bus.wdata;
          REG_BASE_REPEATS: cur_cfg.base_repeats = cfg_bus.wdata;
          REG_VALUE_BITS:   cur_cfg.value_bits = cfg_bus.wdata[3:0];
          REG_REPEATS_BITS: cur_cfg.repeats_bits = cfg_bus.wdata[3:0];
          default: ;
        endcase
      end
      // compare before predicting so an early word cannot match its own prediction
      if (out_bus.valid && out_bus.ready) begin
        if (due_words.size() == 0) begin
          $error("word with none expected: kind %0d last %0d", out_bus.kind, out_bus.last);
          n_bad++;
        end else begin
          want = due_words.pop_front();
          check_field("kind", 28'(want.kind), 28'(out_bus.kind));
          check_field("value_code", 28'(want.value_code), 28'(out_bus.value_code));
          check_field("value_len", 28'(want.value_len), 28'(out_bus.value_len));
          check_field("repeats_code", 28'(want.repeats_code), 28'(out_bus.repeats_code));
          check_field("repeats_len", 28'(want.repeats_len), 28'(out_bus.repeats_len));
          check_field("low_value", 28'(want.low_value), 28'(out_bus.low_value));
          check_field("high_value", 28'(want.high_value), 28'(out_bus.high_value));
          check_field("low_repeats", 28'(want.low_repeats), 28'(out_bus.low_repeats));
          check_field("high_repeats", 28'(want.high_repeats), 28'(out_bus.high_repeats));
          check_field("total_bits", want.total_bits, out_bus.total_bits);
          check_field("last", 28'(want.last), 28'(out_bus.last));
        end
      end
      if (in_bus.valid && in_bus.ready) track_word(in_bus.action, in_bus.data);
    end
    due_count <= due_words.size();
    fail_count <= n_bad;
  end

endmodule

[tb/sv/tb_byte_run_length_scan_and_encode.sv]
`timescale 1ns / 1ps

module tb_byte_run_length_scan_and_encode;
  import brle_pkg::*;

  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned REGIME_WORDS = 420;

  logic clk;
  logic rst_n;

  brle_in_if  in_ch ();
  brle_out_if out_ch ();
  brle_cfg_if cfg_ch ();

  int unsigned n_fail;
  int unsigned n_due;
  int unsigned stuck;
  int unsigned sent;
  int unsigned src_idle;
  int unsigned sink_idle;
  bit          hold_req;

  byte_run_length_scan_and_encode dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  brle_run_checker run_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_ch),
    .out_bus    (out_ch),
    .cfg_bus    (cfg_ch),
    .fail_count (n_fail),
    .due_count  (n_due)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("tb_byte_run_length_scan_and_encode failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] pick_width();
    if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic cfg_t make_config(input logic m, input logic [7:0] bv,
                                       input logic [7:0] br, input logic [3:0] vb,
                                       input logic [3:0] rb);
    cfg_t c;
    c.mode = m;
    c.base_value = bv;
    c.base_repeats = br;
    c.value_bits = vb;
    c.repeats_bits = rb;
    return c;
  endfunction

  function automatic cfg_t pick_config();
    logic [7:0] br;
    br = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 4)) : pick_byte();
    return make_config(1'($urandom_range(0, 1)), pick_byte(), br, pick_width(),
                       pick_width());
  endfunction

  // valid stays high between back-to-back words, it only drops on an idle cycle
  task automatic put_word(input logic act, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.data <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // stop sending, wait for every expected word, then let the pipeline empty
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_reg_t regs [5];
    regs = '{REG_MODE, REG_BASE_VALUE, REG_BASE_REPEATS, REG_VALUE_BITS, REG_REPEATS_BITS};
    foreach (regs[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.idx <= regs[i];
      case (regs[i])
        REG_MODE:         cfg_ch.wdata <= {7'd0, c.mode};
        REG_BASE_VALUE:   cfg_ch.wdata <= c.base_value;
        REG_BASE_REPEATS: cfg_ch.wdata <= c.base_repeats;
        REG_VALUE_BITS:   cfg_ch.wdata <= {4'd0, c.value_bits};
        default:          cfg_ch.wdata <= {4'd0, c.repeats_bits};
      endcase
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int unsigned pick_run_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    // long runs cross the 255 cap
    return $urandom_range(250, 270);
  endfunction

  task automatic well_formed_block();
    int unsigned n_runs;
    int unsigned len;
    bit          tight;
    logic [7:0]  anchor;
    logic [7:0]  v;
    n_runs = $urandom_range(1, 10);
    tight = ($urandom_range(0, 2) == 0);
    anchor = pick_byte();
    repeat (n_runs) begin
      v = tight ? anchor + 8'($urandom_range(0, 1)) : pick_byte();
      len = pick_run_len();
      repeat (len) put_word(ACT_DATA, v);
    end
    // sometimes leave the block open across the next config write
    if ($urandom_range(0, 6) != 0) put_word(ACT_END, 8'($urandom));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 3) == 0) put_word(ACT_END, 8'($urandom));
      else put_word(ACT_DATA, ($urandom_range(0, 1) == 0) ? pick_byte() : 8'($urandom_range(0, 2)));
    end
  endtask

  task automatic random_phase();
    int unsigned quota;
    int unsigned start;
    load_config(pick_config());
    quota = $urandom_range(30, 160);
    start = sent;
    while (sent - start < quota) begin
      if ($urandom_range(0, 9) == 0) noise_burst();
      else well_formed_block();
    end
    quiesce();
  endtask

  // code mode with every neighbor different fills the block while the receiver holds off
  task automatic pressure_burst();
    cfg_t c;
    c = pick_config();
    c.mode = MODE_CODE;
    load_config(c);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      put_word(ACT_DATA, i[0] ? 8'h5A : 8'hA5);
    end
    put_word(ACT_END, 8'h00);
    quiesce();
  endtask

  initial begin
    int unsigned stop_at;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_DATA;
    in_ch.data <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.idx <= REG_MODE;
    cfg_ch.wdata <= 8'h00;
    hold_req = 1'b0;
    sent = 0;
    src_idle = 30;
    sink_idle = 67;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scan mode from reset: empty block, then byte extremes and a short block
    put_word(ACT_END, 8'h00);
    put_word(ACT_DATA, 8'h00);
    put_word(ACT_DATA, 8'h00);
    put_word(ACT_DATA, 8'hFF);
    repeat (3) put_word(ACT_DATA, 8'h80);
    put_word(ACT_END, 8'hFF);
    quiesce();

    // code mode, top bases and widths above 8; empty block gives nothing
    load_config(make_config(MODE_CODE, 8'hFF, 8'hFF, 4'd15, 4'd9));
    put_word(ACT_END, 8'h3C);
    put_word(ACT_DATA, 8'hFF);
    put_word(ACT_DATA, 8'h00);
    put_word(ACT_DATA, 8'h00);
    put_word(ACT_END, 8'h00);
    quiesce();

    // zero widths, then switch to scan mode with a run still open
    load_config(make_config(MODE_CODE, 8'h00, 8'h00, 4'd0, 4'd0));
    put_word(ACT_DATA, 8'h7F);
    put_word(ACT_DATA, 8'h01);
    quiesce();
    load_config(make_config(MODE_SCAN, 8'h10, 8'h01, 4'd8, 4'd8));
    put_word(ACT_DATA, 8'h01);
    put_word(ACT_DATA, 8'h02);
    put_word(ACT_END, 8'h55);
    quiesce();

    for (int k = 0; k < 3; k++) begin
      src_idle = (k == 0) ? 30 : (k == 1) ? 67 : 0;
      sink_idle = (k == 0) ? 67 : (k == 1) ? 30 : 0;
      if (k == 0) pressure_burst();
      stop_at = sent + REGIME_WORDS;
      while (sent < stop_at) random_phase();
    end

    quiesce();
    repeat (10) @(posedge clk);
    if (n_fail == 0 && n_due == 0) begin
      $display("tb_byte_run_length_scan_and_encode passed");
    end else begin
      $display("tb_byte_run_length_scan_and_encode failed");
    end
    $finish;
  end

endmodule
